// ===== hw/rtl/csds_pkg.sv =====
`default_nettype none
package csds_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;

  localparam logic [15:0] SCALE_ONE = 16'd4096;
  localparam logic [26:0] PATH_MAX = 27'h7FF_FFFF;

  localparam int SQ_RW = 22;
  localparam int SQ_VW = 2 * SQ_RW;

  localparam logic [15:0] RECIP100 = 16'd41943;
  localparam int RECIP_SH = 22;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] CFG_MAX_SCALE = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_THRESH = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_GROW = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SHRINK = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_WINDOW = 3'd4;

  typedef struct packed {
    logic        pos_valid;
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
    logic [31:0] time_ms;
  } item_t;

  typedef struct packed {
    logic [9:0]  max_pct;
    logic [15:0] thresh;
    logic [6:0]  grow;
    logic [6:0]  shrink;
    logic [15:0] window;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        net;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] bx;
    logic [15:0] by;
  } pair_t;

  typedef struct packed {
    logic             valid;
    logic             net;
    logic [SQ_RW-1:0] value;
  } dist_t;

  typedef struct packed {
    logic go;
    logic clr;
  } hist_evt_t;

  typedef struct packed {
    logic [15:0] current_scale;
    logic [15:0] target_scale;
    logic        overlay_on;
    logic        fast_tick;
    logic [26:0] path_length;
  } result_t;

  typedef enum logic [2:0] {
    H_IDLE, H_PRUNE_RD, H_PRUNE_CHK, H_WALK, H_TAIL, H_NET
  } hist_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MX1, S_MX2, S_DEC, S_GAP, S_D1, S_D2, S_OUT
  } scale_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/csds_if.sv =====
`default_nettype none
interface csds_in_if;
  logic        valid;
  logic        ready;
  logic        pos_valid;
  logic [15:0] cursor_x;
  logic [15:0] cursor_y;
  logic [31:0] time_ms;
  modport source (output valid, pos_valid, cursor_x, cursor_y, time_ms, input ready);
  modport sink (input valid, pos_valid, cursor_x, cursor_y, time_ms, output ready);
endinterface

interface csds_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] current_scale;
  logic [15:0] target_scale;
  logic        overlay_on;
  logic        fast_tick;
  logic [26:0] path_length;
  modport source (output valid, current_scale, target_scale, overlay_on, fast_tick,
                  path_length, input ready);
  modport sink (input valid, current_scale, target_scale, overlay_on, fast_tick,
                path_length, output ready);
endinterface

interface csds_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [csds_pkg::CFG_IW-1:0] index;
  logic [csds_pkg::CFG_DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cursor_shake_detect_scale.sv =====
// Cursor shake detector and scale smoother.
// Channels: in_ch takes one pointer request per tick (pos_valid, cursor_x,
// cursor_y, time_ms); out_ch returns one result per request (current_scale,
// target_scale, overlay_on, fast_tick, path_length); cfg_ch writes the five
// control registers and is always ready, to be used only while idle.
// One request is processed at a time. A usable position is written to the
// history and samples older than the window are aged out one by one. If at
// least two samples remain, the history walk reads one entry per cycle from
// the sample memory, each distance passes a 25 stage pipeline (difference,
// square, sum, square root), and path and net distance feed the target
// decision; with fewer samples the target stays. An unusable position clears
// the history and sets the target to one. The scale then steps toward its
// target, a step that is skipped when the scale already sits on it.
// The next request is taken as soon as the result sits in the output
// register; if the receiver stalls and that register is full, the block
// holds its finished result and stops taking requests.
// Reset empties the history, sets both scales to one (4096) and loads the
// register defaults; no memory sweep is needed.
`default_nettype none
module cursor_shake_detect_scale #(
  parameter int HISTORY_DEPTH = csds_pkg::HISTORY_DEPTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  csds_in_if.sink    in_ch,
  csds_out_if.source out_ch,
  csds_cfg_if.sink   cfg_ch
);

  csds_pkg::cfg_t      cfg_r;
  csds_pkg::item_t     item;
  csds_pkg::pair_t     pair;
  csds_pkg::dist_t     seg_dist;
  csds_pkg::hist_evt_t evt;
  csds_pkg::result_t   res;
  logic                busy_r;
  logic                accept;
  logic                done;

  assign in_ch.ready  = !busy_r;
  assign accept       = in_ch.valid && !busy_r;
  assign cfg_ch.ready = 1'b1;

  assign item.pos_valid = in_ch.pos_valid;
  assign item.cursor_x  = in_ch.cursor_x;
  assign item.cursor_y  = in_ch.cursor_y;
  assign item.time_ms   = in_ch.time_ms;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r         <= 1'b0;
      cfg_r.max_pct  <= 10'd400;
      cfg_r.thresh   <= 16'd2500;
      cfg_r.grow     <= 7'd40;
      cfg_r.shrink   <= 7'd15;
      cfg_r.window   <= 16'd500;
    end else begin
      if (accept) busy_r <= 1'b1;
      else if (done) busy_r <= 1'b0;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          csds_pkg::CFG_MAX_SCALE: cfg_r.max_pct <= cfg_ch.data[9:0];
          csds_pkg::CFG_THRESH:    cfg_r.thresh  <= cfg_ch.data;
          csds_pkg::CFG_GROW:      cfg_r.grow    <= cfg_ch.data[6:0];
          csds_pkg::CFG_SHRINK:    cfg_r.shrink  <= cfg_ch.data[6:0];
          csds_pkg::CFG_WINDOW:    cfg_r.window  <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  csds_hist #(.DEPTH(HISTORY_DEPTH)) u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .item   (item),
    .window (cfg_r.window),
    .pair_o (pair),
    .evt_o  (evt)
  );

  csds_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .pair_i (pair),
    .dist_o (seg_dist)
  );

  csds_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .cfg       (cfg_r),
    .evt_i     (evt),
    .dist_i    (seg_dist),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (res),
    .done      (done)
  );

  assign out_ch.current_scale = res.current_scale;
  assign out_ch.target_scale  = res.target_scale;
  assign out_ch.overlay_on    = res.overlay_on;
  assign out_ch.fast_tick     = res.fast_tick;
  assign out_ch.path_length   = res.path_length;

endmodule
`default_nettype wire

// ===== hw/rtl/csds_hist.sv =====
`default_nettype none
module csds_hist #(
  parameter int DEPTH = csds_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire csds_pkg::item_t     item,
  input  wire logic [15:0]         window,
  output csds_pkg::pair_t          pair_o,
  output csds_pkg::hist_evt_t      evt_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [63:0] mem [DEPTH];
  logic [63:0] mem_q_r;

  csds_pkg::hist_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [31:0]   now_r, now_nxt;
  logic          rv_r, rv_nxt;
  logic          rfirst_r, rfirst_nxt;
  logic [31:0]   first_r, first_nxt;
  logic [31:0]   prev_r, prev_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [63:0]   wr_data;
  logic          full;
  logic [AW-1:0] oldest_a, base;
  logic [31:0]   age;

  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= csds_pkg::H_IDLE;
      count_r  <= '0;
      oldest_r <= '0;
      rv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      oldest_r <= oldest_nxt;
      rv_r     <= rv_nxt;
    end
    addr_r   <= addr_nxt;
    k_r      <= k_nxt;
    now_r    <= now_nxt;
    rfirst_r <= rfirst_nxt;
    first_r  <= first_nxt;
    prev_r   <= prev_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    oldest_nxt = oldest_r;
    addr_nxt   = addr_r;
    k_nxt      = k_r;
    now_nxt    = now_r;
    rv_nxt     = 1'b0;
    rfirst_nxt = rfirst_r;
    first_nxt  = first_r;
    prev_nxt   = prev_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = oldest_r;
    wr_data    = {item.cursor_x, item.cursor_y, item.time_ms};
    full       = (count_r == CW'(DEPTH));
    oldest_a   = full ? slot_add(oldest_r, AW'(1)) : oldest_r;
    base       = full ? AW'(DEPTH - 1) : count_r[AW-1:0];
    wr_addr    = slot_add(oldest_a, base);
    age        = now_r - mem_q_r[31:0];
    pair_o     = '0;
    evt_o      = '0;

    if (rv_r) begin
      prev_nxt = mem_q_r[63:32];
      if (rfirst_r) begin
        first_nxt = mem_q_r[63:32];
      end else begin
        pair_o.valid = 1'b1;
        pair_o.ax    = prev_r[31:16];
        pair_o.ay    = prev_r[15:0];
        pair_o.bx    = mem_q_r[63:48];
        pair_o.by    = mem_q_r[47:32];
      end
    end

    unique case (state_r)
      csds_pkg::H_IDLE: begin
        if (start) begin
          now_nxt = item.time_ms;
          if (!item.pos_valid) begin
            count_nxt  = '0;
            oldest_nxt = '0;
            evt_o.go   = 1'b1;
            evt_o.clr  = 1'b1;
          end else begin
            wr_en      = 1'b1;
            oldest_nxt = oldest_a;
            count_nxt  = full ? CW'(DEPTH) : count_r + CW'(1);
            state_nxt  = csds_pkg::H_PRUNE_RD;
          end
        end
      end
      csds_pkg::H_PRUNE_RD: begin
        rd_en     = 1'b1;
        state_nxt = csds_pkg::H_PRUNE_CHK;
      end
      csds_pkg::H_PRUNE_CHK: begin
        if (count_r != '0 && age > {16'd0, window}) begin
          oldest_nxt = slot_add(oldest_r, AW'(1));
          count_nxt  = count_r - CW'(1);
          state_nxt  = csds_pkg::H_PRUNE_RD;
        end else if (count_r >= CW'(2)) begin
          addr_nxt  = oldest_r;
          k_nxt     = '0;
          state_nxt = csds_pkg::H_WALK;
        end else begin
          evt_o.go  = 1'b1;
          state_nxt = csds_pkg::H_IDLE;
        end
      end
      csds_pkg::H_WALK: begin
        rd_en      = 1'b1;
        rd_addr    = addr_r;
        rv_nxt     = 1'b1;
        rfirst_nxt = (k_r == '0);
        addr_nxt   = slot_add(addr_r, AW'(1));
        k_nxt      = k_r + CW'(1);
        if (k_r == count_r - CW'(1)) state_nxt = csds_pkg::H_TAIL;
      end
      csds_pkg::H_TAIL: begin
        state_nxt = csds_pkg::H_NET;
      end
      csds_pkg::H_NET: begin
        pair_o.valid = 1'b1;
        pair_o.net   = 1'b1;
        pair_o.ax    = first_r[31:16];
        pair_o.ay    = first_r[15:0];
        pair_o.bx    = prev_r[31:16];
        pair_o.by    = prev_r[15:0];
        state_nxt    = csds_pkg::H_IDLE;
      end
      default: state_nxt = csds_pkg::H_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/csds_dist.sv =====
`default_nettype none
module csds_dist (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire csds_pkg::pair_t  pair_i,
  output csds_pkg::dist_t       dist_o
);

  localparam int RW = csds_pkg::SQ_RW;
  localparam int VW = csds_pkg::SQ_VW;

  logic               v1_r, v2_r;
  logic               n1_r, n2_r;
  logic signed [16:0] dx_r, dy_r;
  logic [33:0]        sqx_r, sqy_r;
  logic signed [33:0] dxe, dye;

  logic          vld_r  [RW+1];
  logic          net_r  [RW+1];
  logic [VW-1:0] rem_r  [RW+1];
  logic [RW-1:0] root_r [RW+1];
  logic [VW-1:0] rem_nxt  [RW];
  logic [RW-1:0] root_nxt [RW];
  logic [VW-1:0] trial    [RW];

  assign dxe = 34'(dx_r);
  assign dye = 34'(dy_r);

  always_comb begin
    for (int j = 0; j < RW; j++) begin
      trial[j] = (VW'(root_r[j]) << (RW - j)) | (VW'(1) << (2 * (RW - 1 - j)));
      if (rem_r[j] >= trial[j]) begin
        rem_nxt[j]  = rem_r[j] - trial[j];
        root_nxt[j] = root_r[j] | (RW'(1) << (RW - 1 - j));
      end else begin
        rem_nxt[j]  = rem_r[j];
        root_nxt[j] = root_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int j = 0; j <= RW; j++) vld_r[j] <= 1'b0;
    end else begin
      v1_r     <= pair_i.valid;
      v2_r     <= v1_r;
      vld_r[0] <= v2_r;
      for (int j = 0; j < RW; j++) vld_r[j+1] <= vld_r[j];
    end
    n1_r      <= pair_i.net;
    dx_r      <= 17'($signed(pair_i.ax)) - 17'($signed(pair_i.bx));
    dy_r      <= 17'($signed(pair_i.ay)) - 17'($signed(pair_i.by));
    n2_r      <= n1_r;
    sqx_r     <= $unsigned(dxe * dxe);
    sqy_r     <= $unsigned(dye * dye);
    net_r[0]  <= n2_r;
    rem_r[0]  <= {1'b0, {1'b0, sqx_r} + {1'b0, sqy_r}, 8'd0};
    root_r[0] <= '0;
    for (int j = 0; j < RW; j++) begin
      net_r[j+1]  <= net_r[j];
      rem_r[j+1]  <= rem_nxt[j];
      root_r[j+1] <= root_nxt[j];
    end
  end

  assign dist_o.valid = vld_r[RW];
  assign dist_o.net   = net_r[RW];
  assign dist_o.value = root_r[RW];

endmodule
`default_nettype wire

// ===== hw/rtl/csds_scale.sv =====
`default_nettype none
module csds_scale (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire csds_pkg::cfg_t      cfg,
  input  wire csds_pkg::hist_evt_t evt_i,
  input  wire csds_pkg::dist_t     dist_i,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output csds_pkg::result_t        out_res,
  output logic                     done
);

  csds_pkg::scale_state_t state_r, state_nxt;
  logic [15:0] now_r, now_nxt;
  logic [15:0] goal_r, goal_nxt;
  logic [26:0] path_r, path_nxt;
  logic [21:0] net_r, net_nxt;
  logic [21:0] p_r, p_nxt;
  logic [37:0] prod_r, prod_nxt;
  logic [15:0] maxs_r, maxs_nxt;
  logic [15:0] gap_r, gap_nxt;
  logic        grow_r, grow_nxt;
  logic        out_vld_r, out_vld_nxt;
  csds_pkg::result_t res_r, res_nxt;

  logic [27:0] psum;
  logic [9:0]  pct_c;
  logic [15:0] thr;
  logic [31:0] p32, t32, n32;
  logic        up, dn;
  logic [15:0] q_est, q_fix, delta;
  logic [23:0] rem;
  logic [6:0]  pct_g, pct_s, pct_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= csds_pkg::S_IDLE;
      now_r     <= csds_pkg::SCALE_ONE;
      goal_r    <= csds_pkg::SCALE_ONE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      now_r     <= now_nxt;
      goal_r    <= goal_nxt;
      out_vld_r <= out_vld_nxt;
    end
    path_r <= path_nxt;
    net_r  <= net_nxt;
    p_r    <= p_nxt;
    prod_r <= prod_nxt;
    maxs_r <= maxs_nxt;
    gap_r  <= gap_nxt;
    grow_r <= grow_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    now_nxt     = now_r;
    goal_nxt    = goal_r;
    path_nxt    = path_r;
    net_nxt     = net_r;
    p_nxt       = p_r;
    prod_nxt    = prod_r;
    maxs_nxt    = maxs_r;
    gap_nxt     = gap_r;
    grow_nxt    = grow_r;
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    done        = 1'b0;

    psum  = {1'b0, path_r} + 28'(dist_i.value);
    pct_c = (cfg.max_pct < 10'd100) ? 10'd100 :
            (cfg.max_pct > 10'd1000) ? 10'd1000 : cfg.max_pct;
    thr   = (cfg.thresh == 16'd0) ? 16'd800 : cfg.thresh;
    p32   = 32'(path_r);
    t32   = 32'(thr);
    n32   = 32'(net_r) + 32'd16;
    up    = (p32 > (t32 << 4)) && (p32 * 32'd10 > n32 * 32'd12);
    dn    = (p32 * 32'd5 < (t32 << 5)) || (p32 * 32'd10 <= n32 * 32'd11);
    q_est = prod_r[csds_pkg::RECIP_SH +: 16];
    rem   = {2'b0, p_r} - 24'(q_est) * 24'd100;
    q_fix = (rem >= 24'd100) ? q_est + 16'd1 : q_est;
    pct_g = (cfg.grow == 7'd0 || cfg.grow > 7'd100) ? 7'd40 : cfg.grow;
    pct_s = (cfg.shrink == 7'd0 || cfg.shrink > 7'd100) ? 7'd15 : cfg.shrink;
    pct_u = (goal_r > now_r) ? pct_g : pct_s;
    delta = (q_fix == 16'd0) ? 16'd1 : q_fix;
    if (delta > gap_r) delta = gap_r;

    if (out_vld_r && out_ready) out_vld_nxt = 1'b0;

    if (start) begin
      path_nxt = '0;
    end else if (dist_i.valid && !dist_i.net) begin
      path_nxt = (psum > {1'b0, csds_pkg::PATH_MAX}) ? csds_pkg::PATH_MAX : psum[26:0];
    end
    if (dist_i.valid && dist_i.net) net_nxt = dist_i.value;

    unique case (state_r)
      csds_pkg::S_IDLE: begin
        if (evt_i.go) begin
          if (evt_i.clr) goal_nxt = csds_pkg::SCALE_ONE;
          state_nxt = csds_pkg::S_GAP;
        end else if (dist_i.valid && dist_i.net) begin
          p_nxt     = {pct_c, 12'd0} + 22'd50;
          state_nxt = csds_pkg::S_MX1;
        end
      end
      csds_pkg::S_MX1, csds_pkg::S_D1: begin
        prod_nxt  = 38'(p_r) * 38'(csds_pkg::RECIP100);
        state_nxt = (state_r == csds_pkg::S_MX1) ? csds_pkg::S_MX2 : csds_pkg::S_D2;
      end
      csds_pkg::S_MX2: begin
        maxs_nxt  = q_fix;
        state_nxt = csds_pkg::S_DEC;
      end
      csds_pkg::S_DEC: begin
        if (up) goal_nxt = maxs_r;
        else if (dn) goal_nxt = csds_pkg::SCALE_ONE;
        state_nxt = csds_pkg::S_GAP;
      end
      csds_pkg::S_GAP: begin
        if (goal_r == now_r) begin
          state_nxt = csds_pkg::S_OUT;
        end else begin
          grow_nxt  = goal_r > now_r;
          gap_nxt   = (goal_r > now_r) ? goal_r - now_r : now_r - goal_r;
          p_nxt     = 22'(gap_nxt) * 22'(pct_u);
          state_nxt = csds_pkg::S_D1;
        end
      end
      csds_pkg::S_D2: begin
        now_nxt   = grow_r ? now_r + delta : now_r - delta;
        state_nxt = csds_pkg::S_OUT;
      end
      csds_pkg::S_OUT: begin
        if (!out_vld_r || out_ready) begin
          res_nxt.current_scale = now_r;
          res_nxt.target_scale  = goal_r;
          res_nxt.overlay_on    = now_r > 16'd4177;
          res_nxt.fast_tick     = (now_r > 16'd4100) || (goal_r > 16'd4100);
          res_nxt.path_length   = path_r;
          out_vld_nxt           = 1'b1;
          done                  = 1'b1;
          state_nxt             = csds_pkg::S_IDLE;
        end
      end
      default: state_nxt = csds_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_vld_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

// ===== hw/rtl/csds_chk.sv =====
`default_nettype none
module csds_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] current_scale,
  input wire logic [15:0] target_scale,
  input wire logic        overlay_on,
  input wire logic        fast_tick
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(current_scale) && $stable(target_scale))
    else $error("stalled result changed");

  a_overlay_fast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overlay_on |-> fast_tick)
    else $error("overlay without fast tick");

  a_scale_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> current_scale >= 16'd4096 && target_scale >= 16'd4096)
    else $error("scale below one");

endmodule

bind cursor_shake_detect_scale csds_chk u_csds_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .current_scale (out_ch.current_scale),
  .target_scale  (out_ch.target_scale),
  .overlay_on    (out_ch.overlay_on),
  .fast_tick     (out_ch.fast_tick)
);
`default_nettype wire
